// File: rtl/core/wflm_pkg.sv
package wflm_pkg;

  // Input item: one 1-second tick
  typedef struct packed {
    logic       powered_on;
    logic [2:0] fan_speed;
    logic [9:0] pm25_level;
  } in_t;

  // Result item
  typedef struct packed {
    logic [6:0]  used_percent;
    logic [6:0]  remaining_percent;
    logic        replace_needed;
    logic [15:0] usage_total;
  } out_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_RATED_LIFE     = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_HOUR = 2'd1;
  localparam logic [1:0] CFG_ACCEL_MODE     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] RATED_LIFE_RST     = 16'd20000;
  localparam logic [15:0] TICKS_PER_HOUR_RST = 16'd3600;

  // PM2.5 band bounds
  localparam logic [9:0] PM_BOUND_LOW  = 10'd50;
  localparam logic [9:0] PM_BOUND_MID  = 10'd100;
  localparam logic [9:0] PM_BOUND_HIGH = 10'd150;

  localparam logic [6:0]  PERCENT_FULL  = 7'd100;
  localparam logic [6:0]  REPLACE_LIMIT = 7'd2;
  localparam logic [15:0] USAGE_MAX     = 16'hFFFF;

  // Dividend width: usage times 100
  localparam int unsigned DIVIDEND_W = 23;
  localparam int unsigned QUOT_W     = 7;

  // Wear weight table, tenths of an hour
  function automatic logic [3:0] wear_weight(input logic [1:0] idx);
    logic [3:0] w;
    case (idx)
      2'd0:    w = 4'd5;
      2'd1:    w = 4'd6;
      2'd2:    w = 4'd8;
      default: w = 4'd10;
    endcase
    return w;
  endfunction

  // Fan speed to weight index; unknown speeds weigh as sleep
  function automatic logic [1:0] fan_index(input logic [2:0] fan);
    logic [1:0] idx;
    case (fan)
      3'd2:    idx = 2'd1;
      3'd3:    idx = 2'd2;
      3'd4:    idx = 2'd3;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

  // PM2.5 reading to band index
  function automatic logic [1:0] pm_index(input logic [9:0] pm);
    logic [1:0] idx;
    if (pm < PM_BOUND_LOW) begin
      idx = 2'd0;
    end else if (pm < PM_BOUND_MID) begin
      idx = 2'd1;
    end else if (pm < PM_BOUND_HIGH) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    return idx;
  endfunction

  // Usage times 100 as 64 + 32 + 4
  function automatic logic [DIVIDEND_W-1:0] times100(input logic [15:0] u);
    logic [DIVIDEND_W-1:0] ext;
    ext = {7'd0, u};
    return (ext << 6) + (ext << 5) + (ext << 2);
  endfunction

endpackage

// File: rtl/core/weighted_filter_life_meter.sv
// A new item is taken only after the previous result is written to the output register,
// so items pass one at a time through the 7-step serial percent divider;
// the next item is taken while a finished result waits at the output.
// Reset (rst, synchronous): tick count, usage and replace flag clear; rated life
// 20000, ticks per hour 3600, accelerated mode off; no result pending.
module weighted_filter_life_meter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wflm_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wflm_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_START = 2'd1;
  localparam logic [1:0] P_WAIT  = 2'd2;

  logic [1:0]  phase;
  logic [15:0] rated_life;
  logic [15:0] ticks_per_hour;
  logic        accelerated_mode;
  logic [15:0] tick_count;
  logic [15:0] usage_accum;
  logic        replace_flag;

  logic        in_take;
  logic        running;
  logic        below;
  logic [15:0] tick_inc;
  logic        hour_done;
  logic [16:0] sum;
  logic [15:0] tick_count_next;
  logic [15:0] usage_next;

  logic        div_busy;
  logic [6:0]  quotient;
  logic        out_free;
  logic        res_write;
  logic [6:0]  used;
  logic        replace_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (phase != P_IDLE);
  assign in_take   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rated_life       <= wflm_pkg::RATED_LIFE_RST;
      ticks_per_hour   <= wflm_pkg::TICKS_PER_HOUR_RST;
      accelerated_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wflm_pkg::CFG_RATED_LIFE:     rated_life       <= cfg_data;
        wflm_pkg::CFG_TICKS_PER_HOUR: ticks_per_hour   <= cfg_data;
        wflm_pkg::CFG_ACCEL_MODE:     accelerated_mode <= cfg_data[0];
        default:                      ;
      endcase
    end
  end

  // Tick and usage update for the incoming item
  always_comb begin
    running   = in_data.powered_on && (in_data.fan_speed != 3'd0);
    below     = usage_accum < rated_life;
    tick_inc  = tick_count + 16'd1;
    hour_done = accelerated_mode || (tick_inc >= ticks_per_hour);
    sum       = {1'b0, usage_accum}
              + {13'd0, wflm_pkg::wear_weight(wflm_pkg::fan_index(in_data.fan_speed))}
              + {13'd0, wflm_pkg::wear_weight(wflm_pkg::pm_index(in_data.pm25_level))};
    tick_count_next = tick_count;
    usage_next      = usage_accum;
    if (!running) begin
      tick_count_next = '0;
    end else if (below) begin
      if (hour_done) begin
        tick_count_next = '0;
        usage_next      = sum[16] ? wflm_pkg::USAGE_MAX : sum[15:0];
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      usage_accum <= '0;
    end else if (in_take) begin
      tick_count  <= tick_count_next;
      usage_accum <= usage_next;
    end
  end

  // Sequence one item: update, start divide, wait and deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      case (phase)
        P_IDLE:  if (in_take) phase <= P_START;
        P_START: phase <= P_WAIT;
        P_WAIT:  if (res_write) phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  wflm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (phase == P_START),
    .dividend (wflm_pkg::times100(usage_accum)),
    .divisor  (rated_life),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Percent and replace flag
  assign out_free     = !out_valid || !out_stall;
  assign res_write    = (phase == P_WAIT) && !div_busy && out_free;
  assign used         = (usage_accum >= rated_life) ? wflm_pkg::PERCENT_FULL : quotient;
  assign replace_next = replace_flag ||
                        ((wflm_pkg::PERCENT_FULL - used) <= wflm_pkg::REPLACE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_flag <= 1'b0;
    end else if (res_write) begin
      replace_flag <= replace_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_write) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_data.used_percent      <= used;
      out_data.remaining_percent <= wflm_pkg::PERCENT_FULL - used;
      out_data.replace_needed    <= replace_next;
      out_data.usage_total       <= usage_accum;
    end
  end

  // Divider runs only while a result is awaited
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (phase == P_WAIT))
    else $error("divider busy outside wait phase");

  // Replace flag is sticky
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    replace_flag |=> replace_flag)
    else $error("replace flag cleared");

  // Percents of a delivered result add to 100
  a_percent_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.used_percent + out_data.remaining_percent)
                   == wflm_pkg::PERCENT_FULL))
    else $error("used and remaining percent disagree");

  // A new result is loaded only after the divider finished
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    res_write |-> ($past(phase) == P_WAIT || $past(phase) == P_START))
    else $error("result written without a divide");

endmodule

// File: rtl/core/wflm_div.sv
// Restoring divider, one quotient bit per cycle
module wflm_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wflm_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [15:0]                         divisor,
  output logic                                busy,
  output logic [wflm_pkg::QUOT_W-1:0]         quotient
);

  localparam int unsigned DW = wflm_pkg::DIVIDEND_W;
  localparam int unsigned QW = wflm_pkg::QUOT_W;

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [2:0]    cnt;
  logic [DW:0]   diff;

  // Trial subtract of the aligned divisor
  assign diff = {1'b0, rem} - {1'b0, dreg};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'(QW - 1);
    end else if (busy) begin
      if (cnt == 3'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  // Load operands, then shift the divisor right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dreg     <= {1'b0, divisor, 6'd0};
      quotient <= '0;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
      end
      quotient <= {quotient[QW-2:0], ~diff[DW]};
      dreg     <= dreg >> 1;
    end
  end

endmodule

// File: bench/weighted_filter_life_meter_tb.sv
`timescale 1ns / 1ps

module weighted_filter_life_meter_tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;
  // Index past the last register; the block must ignore it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Track filter wear and queue the readings the meter should report
  class filter_wear_tracker;
    logic [15:0]    rated_life;
    logic [15:0]    ticks_per_hour;
    logic           accel;
    logic [15:0]    tick_count;
    logic [15:0]    usage;
    logic           replace_flag;
    wflm_pkg::out_t readings_due[$];
    int             errors;

    function new();
      rated_life     = wflm_pkg::RATED_LIFE_RST;
      ticks_per_hour = wflm_pkg::TICKS_PER_HOUR_RST;
      accel          = 1'b0;
      tick_count     = '0;
      usage          = '0;
      replace_flag   = 1'b0;
      errors         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        wflm_pkg::CFG_RATED_LIFE:     rated_life = val;
        wflm_pkg::CFG_TICKS_PER_HOUR: ticks_per_hour = val;
        wflm_pkg::CFG_ACCEL_MODE:     accel = val[0];
        default: ;
      endcase
    endfunction

    // Speeds above high weigh as sleep
    function int unsigned fan_wear(logic [2:0] fan);
      int unsigned w;
      case (fan)
        3'd2:    w = 6;
        3'd3:    w = 8;
        3'd4:    w = 10;
        default: w = 5;
      endcase
      return w;
    endfunction

    function int unsigned band_wear(logic [9:0] pm);
      int unsigned w;
      if (pm < wflm_pkg::PM_BOUND_LOW) begin
        w = 5;
      end else if (pm < wflm_pkg::PM_BOUND_MID) begin
        w = 6;
      end else if (pm < wflm_pkg::PM_BOUND_HIGH) begin
        w = 8;
      end else begin
        w = 10;
      end
      return w;
    endfunction

    function void take_tick(wflm_pkg::in_t t);
      int unsigned    total;
      int unsigned    used;
      logic           hour_done;
      wflm_pkg::out_t r;
      // Advance the hour counter only while running below rated life
      if (t.powered_on && t.fan_speed != 3'd0) begin
        if (usage < rated_life) begin
          if (accel) begin
            hour_done = 1'b1;
          end else begin
            tick_count = tick_count + 16'd1;
            hour_done  = (tick_count >= ticks_per_hour);
          end
          if (hour_done) begin
            tick_count = '0;
            total = 32'(usage) + fan_wear(t.fan_speed) + band_wear(t.pm25_level);
            usage = (total > 32'(wflm_pkg::USAGE_MAX)) ? wflm_pkg::USAGE_MAX
                                                       : total[15:0];
          end
        end
      end else begin
        tick_count = '0;
      end
      // Percentages; no divide once usage reaches rated life
      if (usage >= rated_life) begin
        used = 32'(wflm_pkg::PERCENT_FULL);
      end else begin
        used = (32'(usage) * 32'd100) / 32'(rated_life);
      end
      r.used_percent      = used[6:0];
      r.remaining_percent = wflm_pkg::PERCENT_FULL - used[6:0];
      if (r.remaining_percent <= wflm_pkg::REPLACE_LIMIT) replace_flag = 1'b1;
      r.replace_needed = replace_flag;
      r.usage_total    = usage;
      readings_due.push_back(r);
    endfunction

    task log_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task match_reading(wflm_pkg::out_t got);
      wflm_pkg::out_t want;
      if (readings_due.size() == 0) begin
        log_mismatch($sformatf("reading with none pending: %p", got));
      end else begin
        want = readings_due.pop_front();
        if (got.used_percent !== want.used_percent)
          log_mismatch($sformatf("used_percent got %0d want %0d",
                                 got.used_percent, want.used_percent));
        if (got.remaining_percent !== want.remaining_percent)
          log_mismatch($sformatf("remaining_percent got %0d want %0d",
                                 got.remaining_percent, want.remaining_percent));
        if (got.replace_needed !== want.replace_needed)
          log_mismatch($sformatf("replace_needed got %0b want %0b",
                                 got.replace_needed, want.replace_needed));
        if (got.usage_total !== want.usage_total)
          log_mismatch($sformatf("usage_total got %0d want %0d",
                                 got.usage_total, want.usage_total));
      end
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  wflm_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  wflm_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [15:0]    cfg_data;

  filter_wear_tracker meter_sb;
  bit calm;
  bit hold_req;
  int idle_cycles;

  weighted_filter_life_meter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic wflm_pkg::in_t mk_tick(logic on, logic [2:0] fan, logic [9:0] pm);
    wflm_pkg::in_t t;
    t.powered_on = on;
    t.fan_speed  = fan;
    t.pm25_level = pm;
    return t;
  endfunction

  // Mostly running ticks, PM readings often near a band edge
  function automatic wflm_pkg::in_t rand_tick();
    wflm_pkg::in_t t;
    int            pm;
    t.powered_on = ($urandom_range(0, 7) != 0);
    t.fan_speed  = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: pm = $urandom_range(0, 1023);
      1: begin
        case ($urandom_range(0, 2))
          0:       pm = wflm_pkg::PM_BOUND_LOW;
          1:       pm = wflm_pkg::PM_BOUND_MID;
          default: pm = wflm_pkg::PM_BOUND_HIGH;
        endcase
        pm = pm + $urandom_range(0, 3) - 2;
      end
      default: pm = $urandom_range(0, 200);
    endcase
    t.pm25_level = 10'(pm);
    return t;
  endfunction

  // Offer one item, with an optional gap, and hold it until taken
  task automatic send_tick(input wflm_pkg::in_t t);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = t;
    do @(posedge clk); while (in_stall);
    meter_sb.take_tick(t);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    meter_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering and wait for every pending reading
  task automatic drain();
    in_valid = 1'b0;
    while (meter_sb.readings_due.size() != 0) @(negedge clk);
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Check readings and end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) meter_sb.match_reading(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("weighted_filter_life_meter_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned   span;
    logic [15:0]   life;
    logic [15:0]   tph;
    wflm_pkg::in_t t;
    meter_sb  = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: off, fan off, running without a full hour
    send_tick(mk_tick(1'b0, 3'd7, 10'd1023));
    send_tick(mk_tick(1'b1, 3'd0, 10'd0));
    send_tick(mk_tick(1'b1, 3'd4, 10'd0));
    send_tick(mk_tick(1'b1, 3'd1, 10'd1023));
    drain();

    // Zero ticks per hour: every running tick adds wear
    write_cfg(wflm_pkg::CFG_RATED_LIFE, 16'd1000);
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'd0);
    write_cfg(wflm_pkg::CFG_ACCEL_MODE, 16'hFFFE);
    write_cfg(CFG_SPARE, 16'hA5A5);
    send_tick(mk_tick(1'b1, 3'd1, 10'd0));
    send_tick(mk_tick(1'b1, 3'd2, 10'd49));
    send_tick(mk_tick(1'b1, 3'd3, 10'd50));
    send_tick(mk_tick(1'b1, 3'd4, 10'd99));
    send_tick(mk_tick(1'b1, 3'd5, 10'd100));
    send_tick(mk_tick(1'b1, 3'd6, 10'd149));
    send_tick(mk_tick(1'b1, 3'd7, 10'd150));
    send_tick(mk_tick(1'b1, 3'd4, 10'd1023));
    send_tick(mk_tick(1'b0, 3'd4, 10'd1023));
    send_tick(mk_tick(1'b1, 3'd0, 10'd500));
    drain();

    // Two-tick hour; power off in between clears the count
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'd2);
    send_tick(mk_tick(1'b1, 3'd3, 10'd60));
    send_tick(mk_tick(1'b1, 3'd3, 10'd60));
    send_tick(mk_tick(1'b1, 3'd3, 10'd60));
    send_tick(mk_tick(1'b0, 3'd3, 10'd60));
    send_tick(mk_tick(1'b1, 3'd3, 10'd60));
    send_tick(mk_tick(1'b1, 3'd3, 10'd60));
    drain();

    // Accelerated mode ignores the hour length
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'hFFFF);
    write_cfg(wflm_pkg::CFG_ACCEL_MODE, 16'd1);
    send_tick(mk_tick(1'b1, 3'd2, 10'd120));
    send_tick(mk_tick(1'b1, 3'd2, 10'd120));
    drain();

    // Random phases; rated life mostly just above the current wear
    for (int ph = 0; ph < 6; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        life = 16'($urandom_range(1, 65535));
      end else begin
        span = 32'(meter_sb.usage) + $urandom_range(20, 3000);
        life = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
      end
      case ($urandom_range(0, 5))
        0:       tph = 16'($urandom_range(7, 65535));
        1:       tph = 16'd0;
        default: tph = 16'($urandom_range(1, 6));
      endcase
      write_cfg(wflm_pkg::CFG_RATED_LIFE, life);
      write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, tph);
      write_cfg(wflm_pkg::CFG_ACCEL_MODE, {15'($urandom), ($urandom_range(0, 2) == 0)});
      for (int i = 0; i < 68; i++) begin
        if (ph == 1 && i == 30) hold_req = 1'b1;
        send_tick(rand_tick());
      end
      drain();
    end

    // Last part: no idling; smallest rated lives, then the longest one
    calm = 1'b1;
    write_cfg(wflm_pkg::CFG_RATED_LIFE, 16'd1);
    write_cfg(wflm_pkg::CFG_ACCEL_MODE, 16'd0);
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'd1);
    repeat (3) send_tick(rand_tick());
    drain();
    write_cfg(wflm_pkg::CFG_RATED_LIFE, 16'd0);
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'd0);
    send_tick(mk_tick(1'b1, 3'd4, 10'd1023));
    send_tick(mk_tick(1'b0, 3'd1, 10'd0));
    drain();
    write_cfg(wflm_pkg::CFG_RATED_LIFE, 16'hFFFF);
    write_cfg(wflm_pkg::CFG_TICKS_PER_HOUR, 16'hFFFF);
    repeat (5) send_tick(mk_tick(1'b1, 3'd2, 10'd75));
    drain();
    write_cfg(wflm_pkg::CFG_ACCEL_MODE, 16'd1);
    // Wear on every running tick, back to back
    repeat (8) begin
      t = rand_tick();
      t.powered_on = 1'b1;
      if (t.fan_speed == 3'd0) t.fan_speed = 3'd4;
      send_tick(t);
    end
    repeat (4) send_tick(mk_tick(1'b1, 3'd4, 10'd1023));
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (meter_sb.errors == 0) begin
      $display("weighted_filter_life_meter_tb: done, clean");
    end else begin
      $display("weighted_filter_life_meter_tb: done, errors");
    end
    $finish;
  end

endmodule
